FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion helpers, clocked on clk and quiet during reset
`ifndef NO_ASSERTIONS
`define SMDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smdr check failed");
`define SMDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smdr check failed");
`else
`define SMDR_ASSERT_IMP(lbl, ante, cons)
`define SMDR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/smdr_pkg.sv
`timescale 1ns / 1ps
package smdr_pkg;

  localparam logic [2:0] CMD_SCALE_TRUNC = 3'd0;
  localparam logic [2:0] CMD_SCALE_FLOOR = 3'd1;
  localparam logic [2:0] CMD_SCALE_CEIL  = 3'd2;
  localparam logic [2:0] CMD_DIV_FLOOR   = 3'd3;
  localparam logic [2:0] CMD_DIV_CEIL    = 3'd4;
  localparam logic [2:0] CMD_MUL_FLOOR   = 3'd5;
  localparam logic [2:0] CMD_MUL_CEIL    = 3'd6;
  localparam logic [2:0] CMD_NONE        = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
    logic               overflow;
  } out_t;

  // side info that rides along with the division
  typedef struct packed {
    logic [2:0]         command;
    logic               dz;
    logic               q_neg;
    logic signed [31:0] step_b;
  } ctl_t;

endpackage

FILE: src/smdr_front.sv
`timescale 1ns / 1ps
module smdr_front
  import smdr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  in_t                       data_i,
  output logic                      valid_o,
  output ctl_t                      ctl_o,
  output logic [2*DATA_WIDTH-1:0]   num_o,
  output logic [DATA_WIDTH-1:0]     den_o
);
  localparam int W = DATA_WIDTH;
  localparam int P = 2 * DATA_WIDTH;

  // stage 0: operand capture
  logic                v0_r;
  logic [2:0]          cmd0_r;
  logic signed [W-1:0] a0_r, b0_r, c0_r;
  // stage 1: product
  logic                v1_r;
  logic [2:0]          cmd1_r;
  logic signed [W-1:0] a1_r, b1_r, c1_r;
  logic signed [P-1:0] prod1_r, prod1_nxt;
  // stage 2: magnitudes
  logic                v2_r;
  ctl_t                ctl2_r, ctl2_nxt;
  logic [P-1:0]        num2_r, num2_nxt;
  logic [W-1:0]        den2_r, den2_nxt;

  logic                is_scale;
  logic signed [P-1:0] n_s;
  logic signed [W-1:0] d_s;
  logic                n_neg, d_neg;

  assign prod1_nxt = P'(a0_r) * P'(b0_r);

  always_comb begin
    is_scale = (cmd1_r == CMD_SCALE_TRUNC) || (cmd1_r == CMD_SCALE_FLOOR) ||
               (cmd1_r == CMD_SCALE_CEIL);
    n_s      = is_scale ? prod1_r : P'(a1_r);
    d_s      = is_scale ? c1_r : b1_r;
    n_neg    = n_s[P-1];
    d_neg    = d_s[W-1];
    num2_nxt = n_neg ? P'(-n_s) : P'(n_s);
    den2_nxt = d_neg ? W'(-d_s) : W'(d_s);
    ctl2_nxt.command = cmd1_r;
    ctl2_nxt.dz      = (d_s == '0);
    ctl2_nxt.q_neg   = n_neg ^ d_neg;
    ctl2_nxt.step_b  = 32'(b1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r  <= data_i.command;
      a0_r    <= data_i.operand_a[W-1:0];
      b0_r    <= data_i.operand_b[W-1:0];
      c0_r    <= data_i.operand_c[W-1:0];
      cmd1_r  <= cmd0_r;
      a1_r    <= a0_r;
      b1_r    <= b0_r;
      c1_r    <= c0_r;
      prod1_r <= prod1_nxt;
      ctl2_r  <= ctl2_nxt;
      num2_r  <= num2_nxt;
      den2_r  <= den2_nxt;
    end
  end

  assign valid_o = v2_r;
  assign ctl_o   = ctl2_r;
  assign num_o   = num2_r;
  assign den_o   = den2_r;

endmodule

FILE: src/smdr_div_stage.sv
`timescale 1ns / 1ps
module smdr_div_stage
  import smdr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  ctl_t                    ctl_i,
  input  logic [2*DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0]   rem_i,
  input  logic [DATA_WIDTH-1:0]   den_i,
  output logic                    valid_o,
  output ctl_t                    ctl_o,
  output logic [2*DATA_WIDTH-1:0] num_o,
  output logic [DATA_WIDTH-1:0]   rem_o,
  output logic [DATA_WIDTH-1:0]   den_o
);
  localparam int W = DATA_WIDTH;
  localparam int P = 2 * DATA_WIDTH;

  logic         valid_r;
  ctl_t         ctl_r;
  logic [P-1:0] num_r, num_nxt;
  logic [W-1:0] rem_r, rem_nxt, den_r;
  logic [W:0]   rem2, diff;
  logic         ge;

  // one restoring step: numerator bits shift out, quotient bits shift in
  always_comb begin
    rem2    = {rem_i, num_i[P-1]};
    diff    = rem2 - {1'b0, den_i};
    ge      = rem2 >= {1'b0, den_i};
    rem_nxt = ge ? diff[W-1:0] : rem2[W-1:0];
    num_nxt = {num_i[P-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_i;
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      den_r <= den_i;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign num_o   = num_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;

endmodule

FILE: src/smdr_post.sv
`timescale 1ns / 1ps
module smdr_post
  import smdr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  ctl_t                    ctl_i,
  input  logic [2*DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0]   rem_i,
  output logic                    valid_o,
  output out_t                    data_o
);
  localparam int W  = DATA_WIDTH;
  localparam int P  = 2 * DATA_WIDTH;
  localparam int VW = P + 2;

  logic                 v1_r, v2_r, v3_r;
  ctl_t                 ctl1_r, ctl2_r;
  logic signed [VW-1:0] q1_r, q1_nxt;
  logic signed [VW-1:0] val2_r, val2_nxt;
  out_t                 out3_r, out3_nxt;

  logic                 is_floor, is_ceil, is_mult, rnz;
  logic [VW-1:0]        qmag;
  logic signed [W+1:0]  q_small;
  logic signed [W-1:0]  b_w;
  logic signed [W-1:0]  low_w;
  logic [VW-W:0]        top_bits;

  // stage 1: signed quotient with floor or ceiling correction
  always_comb begin
    is_floor = (ctl_i.command == CMD_SCALE_FLOOR) || (ctl_i.command == CMD_DIV_FLOOR) ||
               (ctl_i.command == CMD_MUL_FLOOR);
    is_ceil  = (ctl_i.command == CMD_SCALE_CEIL) || (ctl_i.command == CMD_DIV_CEIL) ||
               (ctl_i.command == CMD_MUL_CEIL);
    rnz      = (rem_i != '0);
    qmag     = VW'(quo_i);
    if (ctl_i.q_neg) begin
      q1_nxt = (is_floor && rnz) ? ~qmag : -qmag;
    end else begin
      q1_nxt = (is_ceil && rnz) ? qmag + VW'(1) : qmag;
    end
  end

  // stage 2: multiply back for the multiple commands
  always_comb begin
    is_mult  = (ctl1_r.command == CMD_MUL_FLOOR) || (ctl1_r.command == CMD_MUL_CEIL);
    q_small  = q1_r[W+1:0];
    b_w      = ctl1_r.step_b[W-1:0];
    val2_nxt = is_mult ? VW'(q_small) * VW'(b_w) : q1_r;
  end

  // stage 3: range check and wrap, or a zero result for a zero divisor or no command
  always_comb begin
    low_w    = val2_r[W-1:0];
    top_bits = val2_r[VW-1:W-1];
    if (ctl2_r.dz || ctl2_r.command == CMD_NONE) begin
      out3_nxt.result         = '0;
      out3_nxt.divide_by_zero = ctl2_r.dz && (ctl2_r.command != CMD_NONE);
      out3_nxt.overflow       = 1'b0;
    end else begin
      out3_nxt.result         = 32'(low_w);
      out3_nxt.divide_by_zero = 1'b0;
      out3_nxt.overflow       = !((&top_bits) || !(|top_bits));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= ctl_i;
      q1_r   <= q1_nxt;
      ctl2_r <= ctl1_r;
      val2_r <= val2_nxt;
      out3_r <= out3_nxt;
    end
  end

  assign valid_o = v3_r;
  assign data_o  = out3_r;

endmodule

FILE: src/scaled_multiply_divide_rounding.sv
`timescale 1ns / 1ps
// channel  | ports                          | beat
// ---------+--------------------------------+--------------------------------
// input    | in_valid, in_ready, in_data    | command and operands a, b, c
// output   | out_valid, out_ready, out_data | result, divide_by_zero, overflow
//
// one beat enters per cycle unless the output stalls; the pipe is built of
// 3 front stages, one restoring divide step per quotient bit, 3 back stages
// the whole pipe advances together; a stalled output beat holds every stage
// rst_n clears the valid bits only, payload registers carry no reset
`include "assert_macros.svh"
module scaled_multiply_divide_rounding
  import smdr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);
  localparam int W = DATA_WIDTH;
  localparam int P = 2 * DATA_WIDTH;

  // pipe advances when the output register is empty or being drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // divider chain taps, index 0 is the front end output
  logic         v_c   [P+1];
  ctl_t         ctl_c [P+1];
  logic [P-1:0] num_c [P+1];
  logic [W-1:0] rem_c [P+1];
  logic [W-1:0] den_c [P+1];

  // decode, a*b product, sign split into magnitudes
  smdr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .data_i  (in_data),
    .valid_o (v_c[0]),
    .ctl_o   (ctl_c[0]),
    .num_o   (num_c[0]),
    .den_o   (den_c[0])
  );
  assign rem_c[0] = '0;

  // one quotient bit per stage
  for (genvar i = 0; i < P; i++) begin : g_div
    smdr_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_c[i]),
      .ctl_i   (ctl_c[i]),
      .num_i   (num_c[i]),
      .rem_i   (rem_c[i]),
      .den_i   (den_c[i]),
      .valid_o (v_c[i+1]),
      .ctl_o   (ctl_c[i+1]),
      .num_o   (num_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .den_o   (den_c[i+1])
    );
  end

  // rounding correction, multiply back, range check, output register
  smdr_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (v_c[P]),
    .ctl_i   (ctl_c[P]),
    .quo_i   (num_c[P]),
    .rem_i   (rem_c[P]),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  // zero divisor gives a clean zero result
  `SMDR_ASSERT_IMP(a_dz_clean, out_valid && out_data.divide_by_zero,
                   out_data.result == '0 && !out_data.overflow)
  // a held output beat freezes the pipe
  `SMDR_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)
  // a beat accepted at the divider head is not lost on the next edge
  `SMDR_ASSERT_NXT(a_div_moves, en && v_c[0], v_c[1])

endmodule
